### src/matrix_vector_multiply_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the matrix-vector multiply block
// Clocked property wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// check outside reset
`define MVM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define MVM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/mvm_pkg.sv
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix-vector multiply block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 4;
   localparam int CFG_W       = 5;
   localparam int FRAC_BITS   = 16;
   localparam int ACC_W       = 2 * VALUE_W + CFG_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CFG_W-1:0] COUNT_MAX = '1;

   localparam logic REQ_MATRIX = 1'b0;
   localparam logic REQ_VECTOR = 1'b1;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        col_index;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        out_row;
      logic signed [VALUE_W-1:0] out_value;
      logic                      saturated;
      logic                      size_error;
      logic                      out_last;
   } rsp_item_type;

   typedef struct packed {
      logic                      mat_we;
      logic                      vec_we;
      logic                      run;
      logic                      size_error;
      logic [CFG_W-1:0]          rows;
      logic [CFG_W-1:0]          cols;
      logic [INDEX_W-1:0]        row;
      logic [INDEX_W-1:0]        col;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

`default_nettype wire

### src/mvm_queue.sv
// ---------------------------------------------------------------------------
// mvm_queue
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_queue
   import mvm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### src/mvm_front.sv
// ---------------------------------------------------------------------------
// mvm_front
// Accepts request transfers, counts vector elements and classifies each
// item into a store, element or run command.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_front
   import mvm_pkg::*;
#(
   parameter int MAX_DIM = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_item_type     req_data,
   output logic             req_stall,
   input  logic [CFG_W-1:0] rows_in_use,
   input  logic [CFG_W-1:0] cols_in_use,
   input  logic             queue_full,
   output logic             push,
   output cmd_type          push_cmd
);

   logic [CFG_W-1:0] count_ff, count_in;
   logic [CFG_W-1:0] count_inc;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      push_cmd            = '0;
      push_cmd.row        = req_data.row_index;
      push_cmd.col        = req_data.col_index;
      push_cmd.value      = req_data.value;
      push_cmd.cols       = cols_in_use;
      push_cmd.rows       = rows_in_use;
      if (rows_in_use == '0) begin
         push_cmd.rows = CFG_W'(1);
      end else if (int'(rows_in_use) > MAX_DIM) begin
         push_cmd.rows = CFG_W'(MAX_DIM);
      end
      count_in = count_ff;
      if (req_data.req_type == REQ_MATRIX) begin
         push_cmd.mat_we = (int'(req_data.row_index) < MAX_DIM) &&
                           (int'(req_data.col_index) < MAX_DIM);
      end else begin
         push_cmd.vec_we = (int'(req_data.col_index) < MAX_DIM);
         if (req_data.last) begin
            push_cmd.run        = 1'b1;
            push_cmd.size_error = (count_inc != cols_in_use) || (cols_in_use == '0) ||
                                  (int'(cols_in_use) > MAX_DIM);
            count_in            = '0;
         end else begin
            count_in = count_inc;
         end
      end
      if (!push) begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### src/mvm_back.sv
// ---------------------------------------------------------------------------
// mvm_back
// Holds the matrix and vector stores and runs the shared multiply-accumulate
// pipeline, one row at a time, into the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mvm_back
   import mvm_pkg::*;
#(
   parameter int MAX_DIM    = 16,
   parameter int DATA_WIDTH = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int TOT_W  = ACC_W - FRAC_BITS;
   localparam int WIDE_W = (DATA_WIDTH > TOT_W) ? DATA_WIDTH : TOT_W;
   localparam logic signed [WIDE_W-1:0] MAXV =
      {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] MINV = ~MAXV;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_DRAIN = 4'b0100,
      S_ERROR = 4'b1000
   } state_type;

   logic [VALUE_W-1:0] mat_mem [MAX_DIM * MAX_DIM];
   logic [VALUE_W-1:0] vec_mem [MAX_DIM];

   state_type                  state_ff, state_in;
   logic [CFG_W-1:0]           rows_ff, rows_in;
   logic [CFG_W-1:0]           cols_ff, cols_in;
   logic [CFG_W-1:0]           r_ff, r_in;
   logic [CFG_W-1:0]           j_ff, j_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic                       a_valid_ff, a_valid_in;
   logic                       b_valid_ff, b_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [VALUE_W-1:0]  mat_rd_ff;
   logic signed [VALUE_W-1:0]  vec_rd_ff;
   logic signed [2*VALUE_W-1:0] prod_ff;
   rsp_item_type               rsp_data_ff, rsp_data_in;

   logic                       out_free;
   logic                       load_row;
   logic                       load_err;
   logic [ADDR_W-1:0]          mat_waddr;
   logic [ADDR_W-1:0]          mat_raddr;
   logic signed [WIDE_W-1:0]   total;
   logic signed [WIDE_W-1:0]   clipped;
   logic                       clip;

   assign cmd_pop   = cmd_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_row  = (state_ff == S_DRAIN) && !a_valid_ff && !b_valid_ff && out_free;
   assign load_err  = (state_ff == S_ERROR) && out_free;
   assign mat_waddr = ADDR_W'(cmd.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.col);
   assign mat_raddr = base_ff + ADDR_W'(j_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      total   = WIDE_W'(acc_ff >>> FRAC_BITS);
      clipped = total;
      clip    = 1'b0;
      if (total > MAXV) begin
         clipped = MAXV;
         clip    = 1'b1;
      end else if (total < MINV) begin
         clipped = MINV;
         clip    = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      r_in         = r_ff;
      j_in         = j_ff;
      base_in      = base_ff;
      a_valid_in   = 1'b0;
      b_valid_in   = a_valid_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (b_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop && cmd.run) begin
               rows_in  = cmd.rows;
               cols_in  = cmd.cols;
               r_in     = '0;
               j_in     = '0;
               base_in  = '0;
               acc_in   = '0;
               state_in = cmd.size_error ? S_ERROR : S_ISSUE;
            end
         end
         S_ISSUE: begin
            a_valid_in = 1'b1;
            j_in       = j_ff + 1'b1;
            if (j_ff == cols_ff - 1'b1) begin
               j_in     = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (load_row) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_row    = r_ff[INDEX_W-1:0];
               rsp_data_in.out_value  = clipped[VALUE_W-1:0];
               rsp_data_in.saturated  = clip;
               rsp_data_in.size_error = 1'b0;
               rsp_data_in.out_last   = (r_ff == rows_ff - 1'b1);
               acc_in                 = '0;
               if (r_ff == rows_ff - 1'b1) begin
                  state_in = S_IDLE;
               end else begin
                  r_in     = r_ff + 1'b1;
                  base_in  = base_ff + ADDR_W'(MAX_DIM);
                  state_in = S_ISSUE;
               end
            end
         end
         S_ERROR: begin
            if (load_err) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.out_row    = '0;
               rsp_data_in.out_value  = '0;
               rsp_data_in.saturated  = 1'b0;
               rsp_data_in.size_error = 1'b1;
               rsp_data_in.out_last   = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= '0;
         cols_ff      <= '0;
         r_ff         <= '0;
         j_ff         <= '0;
         base_ff      <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         r_ff         <= r_in;
         j_ff         <= j_in;
         base_ff      <= base_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      prod_ff     <= mat_rd_ff * vec_rd_ff;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.mat_we) begin
         mat_mem[mat_waddr] <= cmd.value;
      end
      if (state_ff == S_ISSUE) begin
         mat_rd_ff <= mat_mem[mat_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.vec_we) begin
         vec_mem[IDX_W'(cmd.col)] <= cmd.value;
      end
      if (state_ff == S_ISSUE) begin
         vec_rd_ff <= vec_mem[IDX_W'(j_ff)];
      end
   end

endmodule

`default_nettype wire

### src/matrix_vector_multiply.sv
// ---------------------------------------------------------------------------
// matrix_vector_multiply
// Dense signed Q16.16 matrix-vector product with saturating results.
// ---------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req_data) carries matrix entries
// and vector elements; the element marked last starts a run. Result channel
// (rsp_valid / rsp_stall / rsp_data) returns one transfer per row in row
// order, the final one flagged by out_last, or a single size_error transfer.
// csr_we / csr_index / csr_wdata set rows_in_use and cols_in_use; the user
// must write them only while idle, which the block itself does not enforce.
// Requests enter a four-entry command queue; a store item leaves it whenever
// the back part is idle. During a run one shared multiply-accumulate
// pipeline (read, multiply, accumulate) handles one product per cycle within
// a row and drains at each row end.
// Reset clears the queue, the element count and the result valid, and sets
// both sizes to 2; the stores keep their contents and hold garbage until
// written. A stalled result holds the pipeline at the next row end; req_stall
// rises only when the queue fills.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_multiply
   import mvm_pkg::*;
#(
   parameter int MAX_DIM    = 16,
   parameter int DATA_WIDTH = 32
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_item_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_item_type     rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [CFG_W-1:0] cols_ff, cols_in;
   logic             queue_full;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   logic             pop_valid;
   cmd_type          pop_cmd;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(2);
         cols_ff <= CFG_W'(2);
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   mvm_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .rows_in_use (rows_ff),
      .cols_in_use (cols_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   mvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   mvm_back #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### src/mvm_checker.sv
// ---------------------------------------------------------------------------
// mvm_checker
// Port-level checks on the result and request channels, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_vector_multiply_assert.svh"

module mvm_checker
   import mvm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   `MVM_ASSERT(a_rsp_valid_holds, rsp_valid && rsp_stall |=> rsp_valid, "result valid dropped while stalled")
   `MVM_ASSERT(a_rsp_data_holds, rsp_valid && rsp_stall |=> $stable(rsp_data), "result changed while stalled")
   `MVM_ASSERT(a_error_shape, rsp_valid && rsp_data.size_error |-> rsp_data.out_last && (rsp_data.out_row == '0) && (rsp_data.out_value == '0) && !rsp_data.saturated, "size error result malformed")
   `MVM_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_valid && !(req_valid && req_stall && $past(reset, 2)), "output active right after reset")

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the matrix-vector multiply block.
// ---------------------------------------------------------------------------
// Sends matrix entries and vector elements over the request channel and
// compares every result transfer with a local Q16.16 product model kept at
// full precision. A short table of directed steps covers value extremes,
// saturation, truncation toward minus infinity, repeated indices, ignored
// last flags and size errors, with the obvious results typed in. Random runs
// then sweep row and column settings, clean and broken vectors, element
// count overflow, sender bursts and receiver stalls.
// ---------------------------------------------------------------------------

module tb;
   import mvm_pkg::*;

   localparam int DIM         = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
   localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

   typedef enum int {RUN_CLEAN, RUN_MISCOUNT, RUN_REPEAT, RUN_COUNT_OVERFLOW} run_kind_type;

   typedef struct {
      bit               is_csr;
      logic             csr_idx;
      logic [CFG_W-1:0] csr_val;
      req_item_type     item;
      bit               typed;
      rsp_item_type     fixed_rsp;
   } step_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_item_type     req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_item_type     rsp_data;
   logic             csr_we    = 1'b0;
   logic             csr_index = CSR_ROWS;
   logic [CFG_W-1:0] csr_wdata = '0;

   logic signed [VALUE_W-1:0] mat_model [DIM][DIM];
   logic signed [VALUE_W-1:0] vec_model [DIM];
   logic [CFG_W-1:0]          elem_count = '0;
   logic [CFG_W-1:0]          cfg_rows   = 5'd2;
   logic [CFG_W-1:0]          cfg_cols   = 5'd2;

   rsp_item_type expected_rows[$];
   rsp_item_type product_rows[$];
   step_type     directed_steps[$];

   int errors      = 0;
   int req_count   = 0;
   int rsp_count   = 0;
   int csr_writes  = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_mode  = 0;
   int stall_phase = 0;
   bit sender_gaps = 1'b0;

   matrix_vector_multiply i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      stall_phase = (stall_phase + 1) % 11;
      case (stall_mode)
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= (stall_phase < 4);
         3: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rows.size() == 0) begin
            $error("unexpected result transfer: out_row %0d out_value %h",
                   rsp_data.out_row, rsp_data.out_value);
            errors++;
         end else begin
            want = expected_rows.pop_front();
            if (rsp_data.out_row !== want.out_row) begin
               $error("out_row mismatch: expected %0d, got %0d", want.out_row, rsp_data.out_row);
               errors++;
            end
            if (rsp_data.out_value !== want.out_value) begin
               $error("out_value mismatch: expected %h, got %h",
                      want.out_value, rsp_data.out_value);
               errors++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated mismatch: expected %b, got %b",
                      want.saturated, rsp_data.saturated);
               errors++;
            end
            if (rsp_data.size_error !== want.size_error) begin
               $error("size_error mismatch: expected %b, got %b",
                      want.size_error, rsp_data.size_error);
               errors++;
            end
            if (rsp_data.out_last !== want.out_last) begin
               $error("out_last mismatch: expected %b, got %b", want.out_last, rsp_data.out_last);
               errors++;
            end
         end
      end
   end

   function automatic int clip_size(input logic [CFG_W-1:0] n);
      if (n == 0) return 1;
      if (n > DIM) return DIM;
      return int'(n);
   endfunction

   function automatic void compute_products(input req_item_type it);
      logic [CFG_W-1:0]   taken;
      logic signed [71:0] acc, a, b, q;
      rsp_item_type       r;
      int                 n_rows, i, j;
      product_rows.delete();
      if (it.req_type == REQ_MATRIX) begin
         mat_model[it.row_index][it.col_index] = it.value;
         return;
      end
      vec_model[it.col_index] = it.value;
      if (elem_count != COUNT_MAX) elem_count++;
      if (!it.last) return;
      taken = elem_count;
      elem_count = '0;
      if (taken != cfg_cols || cfg_cols == 0 || cfg_cols > DIM) begin
         r = '0;
         r.size_error = 1'b1;
         r.out_last = 1'b1;
         product_rows.push_back(r);
         return;
      end
      n_rows = clip_size(cfg_rows);
      for (i = 0; i < n_rows; i++) begin
         acc = '0;
         for (j = 0; j < cfg_cols; j++) begin
            a = mat_model[i][j];
            b = vec_model[j];
            acc += a * b;
         end
         q = acc >>> FRAC_BITS;
         r.out_row = i[INDEX_W-1:0];
         r.size_error = 1'b0;
         r.out_last = (i == n_rows - 1);
         if (q > Q_MAX) begin
            r.out_value = Q_MAX[VALUE_W-1:0];
            r.saturated = 1'b1;
         end else if (q < Q_MIN) begin
            r.out_value = Q_MIN[VALUE_W-1:0];
            r.saturated = 1'b1;
         end else begin
            r.out_value = q[VALUE_W-1:0];
            r.saturated = 1'b0;
         end
         product_rows.push_back(r);
      end
   endfunction

   function automatic req_item_type mat_item(input int r, input int c,
                                             input logic [VALUE_W-1:0] v, input bit lst);
      req_item_type it;
      it.req_type = REQ_MATRIX;
      it.row_index = r[INDEX_W-1:0];
      it.col_index = c[INDEX_W-1:0];
      it.value = v;
      it.last = lst;
      return it;
   endfunction

   function automatic req_item_type vec_item(input int c, input logic [VALUE_W-1:0] v,
                                             input bit lst);
      req_item_type it;
      it.req_type = REQ_VECTOR;
      it.row_index = $urandom_range(0, DIM - 1);
      it.col_index = c[INDEX_W-1:0];
      it.value = v;
      it.last = lst;
      return it;
   endfunction

   function automatic step_type item_step(input req_item_type it);
      step_type s;
      s.is_csr = 1'b0;
      s.csr_idx = CSR_ROWS;
      s.csr_val = '0;
      s.item = it;
      s.typed = 1'b0;
      s.fixed_rsp = '0;
      return s;
   endfunction

   function automatic step_type csr_step(input logic idx, input int val);
      step_type s;
      s = item_step('0);
      s.is_csr = 1'b1;
      s.csr_idx = idx;
      s.csr_val = val[CFG_W-1:0];
      return s;
   endfunction

   function automatic step_type with_result(input step_type s, input int orow,
                                            input logic [VALUE_W-1:0] ov, input bit sat,
                                            input bit err, input bit lst);
      step_type t;
      t = s;
      t.typed = 1'b1;
      t.fixed_rsp.out_row = orow[INDEX_W-1:0];
      t.fixed_rsp.out_value = ov;
      t.fixed_rsp.saturated = sat;
      t.fixed_rsp.size_error = err;
      t.fixed_rsp.out_last = lst;
      return t;
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3, 4: return $urandom();
         default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 11))
         0: return 0;
         1: return DIM;
         2: return $urandom_range(DIM + 1, 31);
         3, 4: return $urandom_range(5, DIM - 1);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   task automatic send_item(input req_item_type it, input bit typed,
                            input rsp_item_type fixed_rsp);
      int gap;
      if (sender_gaps && burst_left <= 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      compute_products(it);
      if (typed) expected_rows.push_back(fixed_rsp);
      else foreach (product_rows[k]) expected_rows.push_back(product_rows[k]);
      req_count++;
      burst_left--;
   endtask

   task automatic wait_idle(input int settle);
      @(negedge clock) req_valid <= 1'b0;
      burst_left = 0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CFG_W-1:0];
      @(negedge clock) csr_we <= 1'b0;
      if (idx == CSR_ROWS) cfg_rows = val[CFG_W-1:0];
      else cfg_cols = val[CFG_W-1:0];
      csr_writes++;
   endtask

   task automatic random_run(input run_kind_type kind);
      int order[DIM];
      int n_cols, n_rows, n_items, i, j, k, t;
      n_cols = clip_size(cfg_cols);
      n_rows = clip_size(cfg_rows);
      for (i = 0; i < n_rows; i++)
         for (j = 0; j < n_cols; j++)
            if ($urandom_range(0, 2) == 0)
               send_item(mat_item(i, j, rand_value(), $urandom_range(0, 3) == 0), 1'b0, '0);
      n_items = (cfg_cols == 0) ? $urandom_range(1, 3) : int'(cfg_cols);
      case (kind)
         RUN_MISCOUNT:
            n_items = ($urandom_range(0, 1) && n_items > 1) ? n_items - 1 : n_items + 1;
         RUN_COUNT_OVERFLOW: n_items = $urandom_range(32, 36);
         default: ;
      endcase
      for (i = 0; i < DIM; i++) order[i] = i;
      for (i = n_cols - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         t = order[i];
         order[i] = order[k];
         order[k] = t;
      end
      if (kind == RUN_REPEAT && n_cols > 1) order[$urandom_range(1, n_cols - 1)] = order[0];
      for (i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_item(mat_item($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                               rand_value(), $urandom_range(0, 1)), 1'b0, '0);
         send_item(vec_item((i < DIM) ? order[i] : $urandom_range(0, DIM - 1), rand_value(),
                            i == n_items - 1), 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      step_type     s;
      run_kind_type kind;
      int           start, phases, n_runs, mode, r, i, j;

      directed_steps.push_back(item_step(mat_item(0, 0, 32'h0001_0000, 1'b0)));
      directed_steps.push_back(item_step(mat_item(0, 1, 32'h7FFF_FFFF, 1'b0)));
      directed_steps.push_back(item_step(mat_item(1, 0, 32'h8000_0000, 1'b0)));
      directed_steps.push_back(item_step(mat_item(1, 1, 32'hFFFF_0000, 1'b1)));
      directed_steps.push_back(item_step(vec_item(0, 32'h0002_0000, 1'b0)));
      directed_steps.push_back(item_step(vec_item(1, 32'h7FFF_FFFF, 1'b1)));
      directed_steps.push_back(with_result(item_step(vec_item(1, 32'h0, 1'b1)), 0, 0, 0, 1, 1));
      directed_steps.push_back(item_step(vec_item(1, 32'h0001_8000, 1'b0)));
      directed_steps.push_back(item_step(vec_item(1, 32'hFFFE_8000, 1'b1)));
      directed_steps.push_back(item_step(vec_item(0, 32'h0000_4000, 1'b0)));
      directed_steps.push_back(item_step(vec_item(1, 32'hFFFF_C000, 1'b0)));
      directed_steps.push_back(with_result(item_step(vec_item(0, 32'h1, 1'b1)), 0, 0, 0, 1, 1));
      directed_steps.push_back(csr_step(CSR_ROWS, 1));
      directed_steps.push_back(csr_step(CSR_COLS, 1));
      directed_steps.push_back(item_step(mat_item(0, 0, 32'h8000_0000, 1'b0)));
      directed_steps.push_back(with_result(item_step(vec_item(0, 32'h8000_0000, 1'b1)),
                                           0, 32'h7FFF_FFFF, 1, 0, 1));
      directed_steps.push_back(with_result(item_step(vec_item(0, 32'h7FFF_FFFF, 1'b1)),
                                           0, 32'h8000_0000, 1, 0, 1));
      directed_steps.push_back(with_result(item_step(vec_item(0, 32'hFFFF_FFFF, 1'b1)),
                                           0, 32'h0000_8000, 0, 0, 1));
      directed_steps.push_back(csr_step(CSR_ROWS, 0));
      directed_steps.push_back(with_result(item_step(vec_item(0, 32'h0001_0000, 1'b1)),
                                           0, 32'h8000_0000, 0, 0, 1));
      directed_steps.push_back(item_step(mat_item(0, 0, 32'hFFFF_FFFF, 1'b0)));
      directed_steps.push_back(with_result(item_step(vec_item(0, 32'h0000_8000, 1'b1)),
                                           0, 32'hFFFF_FFFF, 0, 0, 1));
      directed_steps.push_back(csr_step(CSR_COLS, 31));
      directed_steps.push_back(with_result(item_step(vec_item(15, 32'h1234_5678, 1'b1)),
                                           0, 0, 0, 1, 1));
      directed_steps.push_back(csr_step(CSR_COLS, 0));
      directed_steps.push_back(item_step(vec_item(3, 32'h0, 1'b0)));
      directed_steps.push_back(with_result(item_step(vec_item(4, 32'hFFFF_FFFF, 1'b1)),
                                           0, 0, 0, 1, 1));

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      sender_gaps = 1'b1;
      stall_mode = 1;
      foreach (directed_steps[k]) begin
         s = directed_steps[k];
         if (s.is_csr) begin
            wait_idle(24);
            write_csr(s.csr_idx, s.csr_val);
         end else begin
            send_item(s.item, s.typed, s.fixed_rsp);
         end
      end

      // fill every matrix and vector entry at the largest size
      wait_idle(24);
      write_csr(CSR_ROWS, 31);
      write_csr(CSR_COLS, DIM);
      for (i = 0; i < DIM; i++)
         for (j = 0; j < DIM; j++)
            send_item(mat_item(i, j, rand_value(), 1'b0), 1'b0, '0);
      random_run(RUN_CLEAN);

      start = req_count;
      phases = 0;
      while (req_count - start < 100 || phases < 6) begin
         wait_idle(24);
         mode = $urandom_range(0, 3);
         sender_gaps = (mode != 0);
         stall_mode = (mode == 0) ? 0 : $urandom_range(1, 3);
         write_csr(CSR_ROWS, pick_size());
         write_csr(CSR_COLS, pick_size());
         n_runs = (phases == 0) ? 2 : $urandom_range(1, 3);
         for (r = 0; r < n_runs; r++) begin
            if (r > 0 && (phases == 0 || $urandom_range(0, 2) == 0)) wait_idle(0);
            case ($urandom_range(0, 19))
               14, 15: kind = RUN_MISCOUNT;
               16, 17: kind = RUN_REPEAT;
               18: kind = RUN_COUNT_OVERFLOW;
               default: kind = RUN_CLEAN;
            endcase
            random_run(kind);
         end
         phases++;
      end

      wait_idle(40);
      $display("Ran %0d request transfers, %0d result transfers and %0d register writes",
               req_count, rsp_count, csr_writes);
      $display("over sizes 0 to 31, with saturation, truncation, size and count errors.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
